// File: rtl/tdpc_pkg.sv
// shared constants and controller/datapath interface types for the prime counter
package tdpc_pkg;

  localparam int NUMBER_WIDTH = 16;
  localparam int LIMIT_W      = 16;
  localparam int COUNT_W      = 16;
  // divisor never exceeds 2^(NUMBER_WIDTH/2)
  localparam int DIV_W        = NUMBER_WIDTH / 2 + 1;
  localparam int REM_W        = DIV_W + 1;
  localparam int IDX_W        = $clog2(NUMBER_WIDTH);
  localparam int CMP_W        = (NUMBER_WIDTH > LIMIT_W) ? NUMBER_WIDTH : LIMIT_W;
  localparam int SQ_W         = 2 * DIV_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [DIV_W-1:0]   FIRST_DIV   = DIV_W'(2);
  localparam logic [IDX_W-1:0]   TOP_BIT     = IDX_W'(NUMBER_WIDTH - 1);

  typedef struct packed {
    logic load;       // capture input transaction
    logic mod_start;  // clear remainder, set bit index to the top bit
    logic mod_step;   // one restoring step of the modulo
    logic next_div;   // advance divisor
    logic finish;     // write result into output register
    logic prime;      // result flag that goes with finish
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic below_two;  // number is 0 or 1
    logic sq_gt;      // divisor squared exceeds number
    logic mod_last;   // current step is the final bit
    logic rem_zero;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/trial_division_prime_counter_unit.sv
// top level of the trial-division prime counter
//
// input channel: in_valid_i/in_ready_o carry number_i and last_i; one
//   transaction is taken only while the unit is idle
// output channel: out_valid_o/out_ready_i carry prime_flag_o, in_range_o,
//   prime_count_o and run_end_o, exactly one result transaction per input
// config: cfg_we_i writes upper_limit from cfg_wdata_i at once; the user must
//   write it only while idle, as the block itself does not enforce this
// out-of-range numbers and 0/1 go from the range check straight to the
//   result; otherwise each divisor tried costs a square compare,
//   NUMBER_WIDTH restoring modulo steps and a remainder check, with up to
//   254 divisors tried for 16-bit numbers; one item at a time, and the shared
//   one-bit-per-cycle modulo unit sets the rate
// the result sits in an output register; the next transaction is accepted
//   while it waits, and only the final write stalls if the receiver is slow
// reset: upper_limit returns to 1000, running count clears, no result valid
// the count saturates at its maximum and clears after a run_end result
module trial_division_prime_counter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tdpc_pkg::LIMIT_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tdpc_pkg::NUMBER_WIDTH-1:0] number_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              prime_flag_o,
  output logic                              in_range_o,
  output logic [tdpc_pkg::COUNT_W-1:0]      prime_count_o,
  output logic                              run_end_o
);
  import tdpc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  tdpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tdpc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .number_i      (number_i),
    .last_i        (last_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prime_flag_o  (prime_flag_o),
    .in_range_o    (in_range_o),
    .prime_count_o (prime_count_o),
    .run_end_o     (run_end_o)
  );

endmodule

// File: rtl/tdpc_ctrl.sv
// controller state machine sequencing divisor trials and modulo steps
module tdpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tdpc_pkg::stat_t stat_i,
  output tdpc_pkg::cmd_t  cmd_o
);
  import tdpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MOD,
    S_EVAL,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   prime_q, prime_d;

  always_comb begin
    state_d    = state_q;
    prime_d    = prime_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.in_range || stat_i.below_two) begin
          prime_d = 1'b0;
          state_d = S_DONE;
        end else if (stat_i.sq_gt) begin
          prime_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.mod_start = 1'b1;
          state_d         = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.rem_zero) begin
          prime_d = 1'b0;
          state_d = S_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.prime  = prime_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prime_q <= prime_d;
    end
  end

endmodule

// File: rtl/tdpc_datapath.sv
// datapath: operand, divisor, remainder, running count and output registers
module tdpc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tdpc_pkg::LIMIT_W-1:0]      cfg_wdata_i,
  input  logic [tdpc_pkg::NUMBER_WIDTH-1:0] number_i,
  input  logic                              last_i,
  input  tdpc_pkg::cmd_t                    cmd_i,
  output tdpc_pkg::stat_t                   stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              prime_flag_o,
  output logic                              in_range_o,
  output logic [tdpc_pkg::COUNT_W-1:0]      prime_count_o,
  output logic                              run_end_o
);
  import tdpc_pkg::*;

  logic [LIMIT_W-1:0]      limit_q;
  logic [NUMBER_WIDTH-1:0] num_q;
  logic                    last_q;
  logic [DIV_W-1:0]        div_q;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [IDX_W-1:0]        idx_q;
  logic [COUNT_W-1:0]      count_q, count_new;
  logic                    out_valid_q;
  logic                    in_range;
  logic [SQ_W-1:0]         square;
  logic [REM_W-1:0]        shifted;

  assign in_range = CMP_W'(num_q) <= CMP_W'(limit_q);
  assign square   = SQ_W'(div_q) * SQ_W'(div_q);

  // restoring remainder step, one dividend bit per cycle
  assign shifted = {rem_q[DIV_W-1:0], num_q[idx_q]};
  always_comb begin
    if (shifted >= REM_W'(div_q)) begin
      rem_d = shifted - REM_W'(div_q);
    end else begin
      rem_d = shifted;
    end
  end

  assign count_new = (cmd_i.prime && (count_q != COUNT_MAX)) ? count_q + COUNT_W'(1)
                                                              : count_q;

  assign stat_o.in_range  = in_range;
  assign stat_o.below_two = num_q < NUMBER_WIDTH'(2);
  assign stat_o.sq_gt     = square > SQ_W'(num_q);
  assign stat_o.mod_last  = idx_q == '0;
  assign stat_o.rem_zero  = rem_q == '0;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        count_q     <= last_q ? '0 : count_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q  <= number_i;
      last_q <= last_i;
      div_q  <= FIRST_DIV;
    end
    if (cmd_i.next_div) begin
      div_q <= div_q + DIV_W'(1);
    end
    if (cmd_i.mod_start) begin
      rem_q <= '0;
      idx_q <= TOP_BIT;
    end
    if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      idx_q <= idx_q - IDX_W'(1);
    end
    if (cmd_i.finish) begin
      prime_flag_o  <= cmd_i.prime;
      in_range_o    <= in_range;
      prime_count_o <= count_new;
      run_end_o     <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/tdpc_checker.sv
// port-level checker for the prime counter and its bind
module tdpc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              prime_flag_o,
  input logic                              in_range_o,
  input logic [tdpc_pkg::COUNT_W-1:0]      prime_count_o
);

  // result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a prime is never reported outside the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prime_flag_o |-> in_range_o)
    else $error("prime flagged out of range");

  // a prime result always includes itself in the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prime_flag_o |-> prime_count_o != '0)
    else $error("prime with zero count");

  // the unit is busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted two transactions back to back");

endmodule

bind trial_division_prime_counter_unit tdpc_checker u_tdpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .prime_flag_o  (prime_flag_o),
  .in_range_o    (in_range_o),
  .prime_count_o (prime_count_o)
);

// File: tb/sv/tb_trial_division_prime_counter_unit.sv
// self-checking testbench for the trial-division prime counter unit
`timescale 1ns / 1ps

module tb_trial_division_prime_counter_unit;

  localparam int NW = tdpc_pkg::NUMBER_WIDTH;
  localparam int LW = tdpc_pkg::LIMIT_W;
  localparam int CW = tdpc_pkg::COUNT_W;

  // everything one result transaction carries, in port order
  typedef struct packed {
    logic          prime;
    logic          in_range;
    logic [CW-1:0] count;
    logic          run_end;
  } verdict_t;

  // scoreboard: keeps its own limit and running count, predicts one verdict per
  // accepted number and compares results in order
  class prime_scoreboard;
    logic [LW-1:0] upper_limit;
    logic [CW-1:0] run_count;
    verdict_t      expected_verdicts[$];
    logic [NW-1:0] pending_numbers[$];
    int unsigned   mismatches;

    function new();
      upper_limit = tdpc_pkg::LIMIT_RESET;
      run_count   = '0;
      mismatches  = 0;
    endfunction

    function bit trial_divide(logic [NW-1:0] n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic [NW-1:0] n, logic run_last);
      verdict_t v;
      v.in_range = (n <= upper_limit);
      // out-of-range numbers are never tested
      v.prime = v.in_range && trial_divide(n);
      if (v.prime && run_count != tdpc_pkg::COUNT_MAX) run_count = run_count + 1'b1;
      v.count   = run_count;
      v.run_end = run_last;
      if (run_last) run_count = '0;
      expected_verdicts.push_back(v);
      pending_numbers.push_back(n);
    endfunction

    // one line per mismatch, every mismatch counted
    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(verdict_t got);
      verdict_t      want;
      logic [NW-1:0] n;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result transaction with no number pending");
        return;
      end
      want = expected_verdicts.pop_front();
      n    = pending_numbers.pop_front();
      if (got.prime !== want.prime)
        report_mismatch($sformatf("number %0d: prime flag %b, expected %b",
                                  n, got.prime, want.prime));
      if (got.in_range !== want.in_range)
        report_mismatch($sformatf("number %0d: in_range %b, expected %b",
                                  n, got.in_range, want.in_range));
      if (got.count !== want.count)
        report_mismatch($sformatf("number %0d: prime_count %0d, expected %0d",
                                  n, got.count, want.count));
      if (got.run_end !== want.run_end)
        report_mismatch($sformatf("number %0d: run_end %b, expected %b",
                                  n, got.run_end, want.run_end));
    endtask

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // block ports, every input known from time zero
  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_we_i    = 1'b0;
  logic [LW-1:0] cfg_wdata_i = '0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  logic [NW-1:0] number_i    = '0;
  logic          last_i      = 1'b0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic          prime_flag_o;
  logic          in_range_o;
  logic [CW-1:0] prime_count_o;
  logic          run_end_o;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  prime_scoreboard sb;

  trial_division_prime_counter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .number_i      (number_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prime_flag_o  (prime_flag_o),
    .in_range_o    (in_range_o),
    .prime_count_o (prime_count_o),
    .run_end_o     (run_end_o)
  );

  always #6 clk_i = ~clk_i;

  // receiver backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // both channels sampled at the same edge; the prediction is made when the
  // input transaction is taken, the check when the result transaction is taken
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_number(number_i, last_i);
    if (out_valid_o && out_ready_i)
      sb.check_result({prime_flag_o, in_range_o, prime_count_o, run_end_o});
  end

  // offer one number and return at the edge where it is taken; valid stays
  // high afterwards so a back-to-back transaction needs no extra assignment
  task send_number(input logic [NW-1:0] n, input logic run_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    number_i   <= n;
    last_i     <= run_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid at the edge of the last accepted transaction, then wait until
  // every result is back and the unit has settled
  task finish_burst();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write, only called while the unit is idle
  task write_upper_limit(input logic [LW-1:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.upper_limit = lim;
  endtask

  // mostly small numbers to keep the run short, some near the limit to hit
  // both sides of it, and a few of full width
  function automatic logic [NW-1:0] pick_number(logic [LW-1:0] lim);
    int unsigned roll;
    int          v;
    roll = $urandom_range(99);
    if (roll < 10) begin
      v = int'($urandom() & ((64'd1 << NW) - 1));
    end else if (roll < 25) begin
      v = int'(lim) + int'($urandom_range(8)) - 4;
      if (v < 0) v = 0;
      if (v > (1 << NW) - 1) v = (1 << NW) - 1;
    end else begin
      v = int'($urandom_range(1200));
    end
    return v[NW-1:0];
  endfunction

  task run_random_phase(input int items, input int unsigned s_pct,
                        input int unsigned r_pct, input logic [LW-1:0] lim);
    write_upper_limit(lim);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (items) send_number(pick_number(lim), ($urandom_range(11) == 0));
    finish_burst();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit of 1000: zero and one, smallest primes, a composite, largest
    // prime under the limit, the limit itself, just above it, a prime above it, all ones
    send_number(0, 1'b0);
    send_number(1, 1'b0);
    send_number(2, 1'b0);
    send_number(3, 1'b0);
    send_number(4, 1'b0);
    send_number(997, 1'b0);
    send_number(1000, 1'b0);
    send_number(1001, 1'b0);
    send_number(1009, 1'b0);
    send_number('1, 1'b1);
    finish_burst();

    // widest limit: prime squares sit right on the divisor bound, largest
    // 16-bit prime, top bit alone, all ones
    write_upper_limit('1);
    send_number(49, 1'b0);
    send_number(961, 1'b0);
    send_number(65521, 1'b0);
    send_number(16'h8000, 1'b0);
    send_number('1, 1'b0);
    send_number(2, 1'b1);
    finish_burst();

    // zero limit: only zero is in range
    write_upper_limit('0);
    send_number(0, 1'b0);
    send_number(1, 1'b0);
    send_number(3, 1'b1);
    finish_burst();

    // limit of one: two is the first number out of range; back-to-back run ends
    write_upper_limit(1);
    send_number(1, 1'b1);
    send_number(0, 1'b1);
    send_number(2, 1'b1);
    finish_burst();

    // short run of the cheapest primes, a composite, then two run ends in a row
    write_upper_limit('1);
    send_number(2, 1'b0);
    send_number(3, 1'b0);
    send_number(4, 1'b0);
    send_number(2, 1'b1);
    send_number(3, 1'b1);
    finish_burst();

    // random part, one idling profile per phase
    run_random_phase(28, 0, 0, LW'($urandom_range(1000, 65535)));
    run_random_phase(28, 59, 0, '1);
    run_random_phase(28, 0, 59, LW'($urandom_range(0, 300)));
    run_random_phase(28, 38, 38, LW'($urandom_range(300, 3000)));

    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/tdpc_pkg.sv
rtl/tdpc_ctrl.sv
rtl/tdpc_datapath.sv
rtl/trial_division_prime_counter_unit.sv
rtl/tdpc_checker.sv
tb/sv/tb_trial_division_prime_counter_unit.sv
